[rtl/core/mdai_pkg.sv]
// ----------------------------------------------------------------------------
// mdai_pkg
// Types, codes and Q16.16 saturating arithmetic for the atom integrator.
// ----------------------------------------------------------------------------
package mdai_pkg;

    localparam int SLOT_W = 5;
    localparam int Q_W    = 32;
    localparam int DT_W   = 31;
    localparam int CFG_W  = 31;

    typedef logic signed [Q_W-1:0] q_t;
    typedef q_t [2:0] vec3_t;

    localparam q_t Q_ONE = 32'sd65536;

    // operation codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // step kinds
    localparam logic [1:0] SK_POS_ONLY = 2'd0;
    localparam logic [1:0] SK_VEL_ONLY = 2'd1;
    localparam logic [1:0] SK_LEAPFROG = 2'd2;
    localparam logic [1:0] SK_VV_TWO   = 2'd3;

    // velocity scaling modes
    localparam logic [1:0] SCALE_NONE   = 2'd0;
    localparam logic [1:0] SCALE_SINGLE = 2'd1;
    localparam logic [1:0] SCALE_GROUP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_STEP_KIND = 2'd0;
    localparam logic [1:0] CFG_SCALING   = 2'd1;
    localparam logic [1:0] CFG_PCOUPLE   = 2'd2;
    localparam logic [1:0] CFG_TIMESTEP  = 2'd3;

    // matrix entry indexes within the matrix part of the store
    localparam logic [2:0] MAT_XX = 3'd0;
    localparam logic [2:0] MAT_YX = 3'd1;
    localparam logic [2:0] MAT_YY = 3'd2;
    localparam logic [2:0] MAT_ZX = 3'd3;
    localparam logic [2:0] MAT_ZY = 3'd4;
    localparam logic [2:0] MAT_ZZ = 3'd5;
    localparam int MAT_N = 6;

    typedef struct packed {
        q_t xx;
        q_t yx;
        q_t yy;
        q_t zx;
        q_t zy;
        q_t zz;
    } mat_t;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot;
        logic signed [31:0] scalar_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
    } out_beat_t;

    // one pipeline stage word; later stages reuse scratch fields
    typedef struct packed {
        vec3_t pos;
        vec3_t vel;
        vec3_t frc;
        vec3_t vn;
        vec3_t pre;
        vec3_t ft;
        vec3_t pm;
        q_t    sv;
        q_t    q3;
        mat_t  mat;
        logic  diag;
    } pl_t;

    function automatic q_t q_sat(input logic signed [63:0] x);
        q_t r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic q_t q_add(input q_t a, input q_t b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return q_sat(s);
    endfunction

    function automatic q_t q_sub(input q_t a, input q_t b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return q_sat(s);
    endfunction

    // round half up, floor shift, saturate
    function automatic q_t q_mul(input q_t a, input q_t b);
        logic signed [63:0] p;
        logic signed [63:0] r;
        p = 64'(a) * 64'(b) + 64'sd32768;
        r = p >>> 16;
        return q_sat(r);
    endfunction

endpackage

[rtl/core/mdai_coef_store.sv]
// ----------------------------------------------------------------------------
// mdai_coef_store
// Lambda memory with per-entry valid bits and the pressure matrix registers.
// ----------------------------------------------------------------------------
module mdai_coef_store
    import mdai_pkg::*;
#(
    parameter int NUM_GROUPS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_slot,
    input  q_t                wr_data,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_slot,
    input  logic [1:0]        scaling_mode,
    output q_t                lam,
    output mat_t              mat
);

    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int XW = ((GW > SLOT_W) ? GW : SLOT_W) + 1;

    q_t              lam_mem [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] lam_vld_reg;
    q_t              rd_data_reg;
    logic            rd_use_reg;
    mat_t            mat_reg;

    logic [XW-1:0] wr_x;
    logic [XW-1:0] rd_x;
    logic [XW-1:0] mat_off;
    logic [2:0]    mat_idx;
    logic          wr_lam;
    logic          wr_mat;
    logic [GW-1:0] ra;
    logic          use_mem;

    assign wr_x    = XW'(wr_slot);
    assign rd_x    = XW'(rd_slot);
    assign mat_off = wr_x - XW'(NUM_GROUPS);
    assign mat_idx = mat_off[2:0];
    assign wr_lam  = wr_en && (wr_x < XW'(NUM_GROUPS));
    assign wr_mat  = wr_en && (wr_x >= XW'(NUM_GROUPS))
                     && (wr_x < XW'(NUM_GROUPS + MAT_N));

    assign ra      = (scaling_mode == SCALE_SINGLE) ? '0 : rd_x[GW-1:0];
    assign use_mem = (scaling_mode == SCALE_SINGLE)
                     || ((scaling_mode == SCALE_GROUP) && (rd_x < XW'(NUM_GROUPS)));

    always_ff @(posedge clk)
    begin
        if (wr_lam)
        begin
            lam_mem[wr_x[GW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= lam_mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lam_vld_reg <= '0;
            rd_use_reg  <= 1'b0;
            mat_reg     <= '0;
        end
        else
        begin
            if (wr_lam)
            begin
                lam_vld_reg[wr_x[GW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_use_reg <= use_mem && lam_vld_reg[ra];
            end
            if (wr_mat)
            begin
                unique case (mat_idx)
                    MAT_XX:  mat_reg.xx <= wr_data;
                    MAT_YX:  mat_reg.yx <= wr_data;
                    MAT_YY:  mat_reg.yy <= wr_data;
                    MAT_ZX:  mat_reg.zx <= wr_data;
                    MAT_ZY:  mat_reg.zy <= wr_data;
                    MAT_ZZ:  mat_reg.zz <= wr_data;
                    default: mat_reg    <= mat_reg;
                endcase
            end
        end
    end

    // entries never written read as one
    assign lam = rd_use_reg ? rd_data_reg : Q_ONE;
    assign mat = mat_reg;

endmodule

[rtl/core/md_atom_integrator_core.sv]
// ----------------------------------------------------------------------------
// md_atom_integrator_core
// Streaming Q16.16 atom integrator: velocity scaling, pressure damping,
// force kick and position drift.
//
// Input beats (in_valid/in_stall) carry either an atom update or a load
// of one coefficient slot (lambda per group, then six matrix entries).
// A load writes the store at acceptance and gives no output beat; the
// next beat already sees it. Each update gives one output beat
// (out_valid/out_stall) from the last stage. One beat is taken per
// cycle while in_stall is low: ten register stages (stage 1 captures,
// the rest multiply, saturate-add or both); the x, y, z velocity
// dependence of the full matrix runs in stages 4-8. The user must write
// the config port (cfg_we, cfg_index, cfg_data) only while idle; the
// block does not enforce it. Reset clears all valid bits, sets step
// kind to leapfrog and lambdas to one (matrix zero). When the receiver
// stalls, each stage holds only while the stage after it is full, so
// bubbles still fill and in_stall rises only when the whole pipe is full.
// ----------------------------------------------------------------------------
module md_atom_integrator_core
    import mdai_pkg::*;
#(
    parameter int NUM_GROUPS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_beat_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_beat_t        out_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int NS = 10;

    logic [1:0]      step_kind_reg;
    logic [1:0]      scaling_reg;
    logic            pcouple_reg;
    logic [DT_W-1:0] timestep_reg;

    pl_t        st_reg [1:NS];
    pl_t        nx     [1:NS];
    logic [NS:1]   vld_reg;
    logic [NS+1:1] en;

    q_t   lam;
    mat_t mat;
    q_t   dt_q;
    q_t   dt_eff;
    logic [2:0] full;
    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    mdai_coef_store #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (in_acc && (in_data.operation == OP_LOAD)),
        .wr_slot      (in_data.slot),
        .wr_data      (in_data.scalar_value),
        .rd_en        (en[1]),
        .rd_slot      (in_data.slot),
        .scaling_mode (scaling_reg),
        .lam          (lam),
        .mat          (mat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_kind_reg <= SK_LEAPFROG;
            scaling_reg   <= SCALE_NONE;
            pcouple_reg   <= 1'b0;
            timestep_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP_KIND: step_kind_reg <= cfg_data[1:0];
                CFG_SCALING:   scaling_reg   <= cfg_data[1:0];
                CFG_PCOUPLE:   pcouple_reg   <= cfg_data[0];
                CFG_TIMESTEP:  timestep_reg  <= cfg_data[DT_W-1:0];
                default:       timestep_reg  <= timestep_reg;
            endcase
        end
    end

    assign dt_q   = {1'b0, timestep_reg};
    assign dt_eff = (step_kind_reg == SK_VV_TWO) ? {2'b00, timestep_reg[DT_W-1:1]} : dt_q;

    // stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[NS+1] = !out_stall;
        for (int k = NS; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_stall = !en[1];

    always_comb
    begin
        q_t de [3];
        for (int k = 1; k <= NS; k++)
        begin
            nx[k] = '0;
        end

        // stage 1: capture atom and matrix snapshot
        nx[1].pos  = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
        nx[1].vel  = {in_data.vel_z, in_data.vel_y, in_data.vel_x};
        nx[1].frc  = {in_data.force_z, in_data.force_y, in_data.force_x};
        nx[1].sv   = in_data.scalar_value;
        nx[1].mat  = mat;
        nx[1].diag = (mat.yx == '0) && (mat.zx == '0) && (mat.zy == '0);

        // stage 2: lambda products, diagonal damping, force times inverse mass
        nx[2] = st_reg[1];
        de[0] = st_reg[1].mat.xx;
        de[1] = st_reg[1].mat.yy;
        de[2] = st_reg[1].mat.zz;
        for (int d = 0; d < 3; d++)
        begin
            nx[2].ft[d] = q_mul(st_reg[1].frc[d], st_reg[1].sv);
            nx[2].pm[d] = q_mul(de[d], st_reg[1].vel[d]);
            if (pcouple_reg && st_reg[1].diag)
                nx[2].pre[d] = q_mul(st_reg[1].vel[d], q_sub(lam, de[d]));
            else
                nx[2].pre[d] = q_mul(lam, st_reg[1].vel[d]);
        end

        // stage 3: kick term times dt
        nx[3] = st_reg[2];
        for (int d = 0; d < 3; d++)
        begin
            nx[3].ft[d] = q_mul(st_reg[2].ft[d], dt_eff);
        end

        // stage 4: finish x
        nx[4] = st_reg[3];
        nx[4].vn[0] = q_add(full[0] ? q_sub(st_reg[3].pre[0], st_reg[3].pm[0])
                                    : st_reg[3].pre[0], st_reg[3].ft[0]);

        // stage 5: off-diagonal products on new x (yx term parked in vn y)
        nx[5] = st_reg[4];
        nx[5].vn[1] = q_mul(st_reg[4].mat.yx, st_reg[4].vn[0]);
        nx[5].q3    = q_mul(st_reg[4].mat.zx, st_reg[4].vn[0]);

        // stage 6: finish y
        nx[6] = st_reg[5];
        nx[6].vn[1] = q_add(full[1] ? q_sub(st_reg[5].pre[1],
                                            q_add(st_reg[5].vn[1], st_reg[5].pm[1]))
                                    : st_reg[5].pre[1], st_reg[5].ft[1]);

        // stage 7: zy term on new y (parked in vn z)
        nx[7] = st_reg[6];
        nx[7].vn[2] = q_mul(st_reg[6].mat.zy, st_reg[6].vn[1]);

        // stage 8: finish z
        nx[8] = st_reg[7];
        nx[8].vn[2] = q_add(full[2] ? q_sub(st_reg[7].pre[2],
                                            q_add(q_add(st_reg[7].q3, st_reg[7].vn[2]),
                                                  st_reg[7].pm[2]))
                                    : st_reg[7].pre[2], st_reg[7].ft[2]);

        // stage 9: drift products
        nx[9] = st_reg[8];
        if (step_kind_reg == SK_POS_ONLY)
            nx[9].vn = st_reg[8].vel;
        for (int d = 0; d < 3; d++)
        begin
            nx[9].pre[d] = q_mul(nx[9].vn[d], dt_q);
        end

        // stage 10: new position
        nx[10] = st_reg[9];
        if (step_kind_reg != SK_VEL_ONLY)
        begin
            for (int d = 0; d < 3; d++)
            begin
                nx[10].pos[d] = q_add(st_reg[9].pos[d], st_reg[9].pre[d]);
            end
        end
    end

    // each finishing stage follows the matrix form of its own beat
    assign full[0] = pcouple_reg && !st_reg[3].diag;
    assign full[1] = pcouple_reg && !st_reg[5].diag;
    assign full[2] = pcouple_reg && !st_reg[7].diag;

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= NS; k++)
        begin
            if (en[k])
                st_reg[k] <= nx[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
                vld_reg[1] <= in_valid && (in_data.operation == OP_UPDATE);
            for (int k = 2; k <= NS; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NS];
    assign out_data  = '{new_pos_x: st_reg[NS].pos[0],
                         new_pos_y: st_reg[NS].pos[1],
                         new_pos_z: st_reg[NS].pos[2],
                         new_vel_x: st_reg[NS].vn[0],
                         new_vel_y: st_reg[NS].vn[1],
                         new_vel_z: st_reg[NS].vn[2]};

endmodule
